/* hw/rtl/rcpcf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcpcf_pkg: shared types and constants
// Field widths, stream packing, command codes and the trimmed-mean helper
// for the RC pulse capture filter.
// ----------------------------------------------------------------------------
package rcpcf_pkg;

  // Defaults for the top-level parameters
  localparam int NUM_CHANNELS_DEF = 4;
  localparam int TIMER_BITS_DEF   = 16;

  // Fixed field widths of the stream items
  localparam int FIELD_W     = 16;
  localparam int CHAN_W      = 2;
  localparam int OUT_FIELDS  = 4;
  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = OUT_FIELDS * FIELD_W;

  // Input tdata bit positions: channel, pin_level, capture_time
  localparam int IN_CHAN_LSB  = 0;
  localparam int IN_LEVEL_BIT = CHAN_W;
  localparam int IN_STAMP_LSB = CHAN_W + 1;

  // Sample ring per channel
  localparam int RING_DEPTH = 4;
  localparam int RING_IDX_W = 2;
  localparam int SUM_W      = FIELD_W + RING_IDX_W;

  // Queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;

  // Configuration port
  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] REG_LOW_LIMIT  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_HIGH_LIMIT = 1'b1;
  localparam logic [FIELD_W-1:0]    LOW_LIMIT_RST  = 16'd800;
  localparam logic [FIELD_W-1:0]    HIGH_LIMIT_RST = 16'd2800;

  // Input op codes carried in tuser
  localparam logic OP_CAPTURE = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  // Classified command kinds
  typedef enum logic [1:0] {
    CMD_RISE,
    CMD_FALL,
    CMD_TICK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [CHAN_W-1:0]   chan;
    logic [FIELD_W-1:0]  stamp;
  } cmd_t;

  typedef logic [RING_DEPTH-1:0][FIELD_W-1:0] ring_t;

  // Mean of the two middle samples: (sum - max - min) / 2, rounded down
  function automatic logic [FIELD_W-1:0] trimmed_mean(input ring_t ring);
    logic [SUM_W-1:0]   sum;
    logic [SUM_W-1:0]   rest;
    logic [FIELD_W-1:0] hi;
    logic [FIELD_W-1:0] lo;
    sum = '0;
    hi  = ring[0];
    lo  = ring[0];
    for (int k = 0; k < RING_DEPTH; k++) begin
      if (ring[k] > hi) hi = ring[k];
      if (ring[k] < lo) lo = ring[k];
      sum = sum + SUM_W'(ring[k]);
    end
    rest = sum - SUM_W'(hi) - SUM_W'(lo);
    return rest[FIELD_W:1];
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/rcpcf_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcpcf_front: input classifier
// Accepts input transfers, sorts them into rise, fall and tick commands,
// drops captures for absent channels and pushes the rest into the queue.
// ----------------------------------------------------------------------------
module rcpcf_front
  import rcpcf_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,
  input  wire logic [IN_TUSER_W-1:0] in_tuser,
  input  wire logic                  q_full,
  output logic                       q_push,
  output cmd_t                       q_cmd
);

  logic op;
  logic keep;

  // Accept whenever the queue has room
  assign in_tready = ~q_full;
  assign op        = in_tuser[0];

  // Classify the item
  always_comb begin
    q_cmd.chan  = in_tdata[IN_CHAN_LSB +: CHAN_W];
    q_cmd.stamp = in_tdata[IN_STAMP_LSB +: FIELD_W];
    if (op == OP_TICK) begin
      q_cmd.kind = CMD_TICK;
    end else if (in_tdata[IN_LEVEL_BIT]) begin
      q_cmd.kind = CMD_RISE;
    end else begin
      q_cmd.kind = CMD_FALL;
    end
    keep = (op == OP_TICK) || (int'(q_cmd.chan) < NUM_CHANNELS);
  end

  // Drop captures on absent channels
  assign q_push = in_tvalid & in_tready & keep;

endmodule
`default_nettype wire

/* hw/rtl/rcpcf_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcpcf_queue: command queue
// Short FIFO of classified commands between the front and the back.
// ----------------------------------------------------------------------------
module rcpcf_queue
  import rcpcf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  output logic      pop_valid,
  input  wire logic pop,
  output cmd_t      pop_cmd
);

  cmd_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_PTR_W:0]   count_r, count_nxt;

  assign full      = (count_r == (Q_PTR_W + 1)'(Q_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_cmd   = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed command
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/rcpcf_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcpcf_back: capture and filter engine
// Holds the limit registers and per-channel state, executes rise, fall and
// tick commands and drives the registered result stream.
// ----------------------------------------------------------------------------
module rcpcf_back
  import rcpcf_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int TIMER_BITS   = TIMER_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [FIELD_W-1:0]     cfg_wdata,
  input  wire logic                   q_valid,
  input  wire cmd_t                   q_cmd,
  output logic                        q_pop,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  localparam int CMP_W = (TIMER_BITS > FIELD_W) ? TIMER_BITS : FIELD_W;

  logic [FIELD_W-1:0]    low_limit_r, high_limit_r;
  logic [TIMER_BITS-1:0] rise_r [NUM_CHANNELS];
  logic [TIMER_BITS-1:0] rise_nxt [NUM_CHANNELS];
  logic [TIMER_BITS-1:0] width_r [NUM_CHANNELS];
  logic [TIMER_BITS-1:0] width_nxt [NUM_CHANNELS];
  logic [FIELD_W-1:0]    last_r [NUM_CHANNELS];
  logic [FIELD_W-1:0]    last_nxt [NUM_CHANNELS];
  ring_t                 ring_r [NUM_CHANNELS];
  ring_t                 ring_nxt [NUM_CHANNELS];
  logic [RING_IDX_W-1:0] slot_r, slot_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic [CMP_W-1:0]      stamp_ext;
  logic [TIMER_BITS-1:0] stamp;
  logic [RING_IDX_W-1:0] slot_adv;
  logic [CMP_W-1:0]      width_ext;
  logic [CMP_W-1:0]      last_ext;
  logic                  in_range;
  logic [FIELD_W-1:0]    checked;
  logic [FIELD_W-1:0]    mean [NUM_CHANNELS];

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Take a command unless a tick would overwrite a stalled result
  assign q_pop = q_valid && ((q_cmd.kind != CMD_TICK) || !out_valid_r || out_tready);

  assign stamp_ext = CMP_W'(q_cmd.stamp);
  assign stamp     = stamp_ext[TIMER_BITS-1:0];
  assign slot_adv  = slot_r + 1'b1;

  // Execute the popped command
  always_comb begin
    rise_nxt      = rise_r;
    width_nxt     = width_r;
    last_nxt      = last_r;
    ring_nxt      = ring_r;
    slot_nxt      = slot_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    width_ext     = '0;
    last_ext      = '0;
    in_range      = 1'b0;
    checked       = '0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      mean[c] = '0;
    end
    if (q_pop) begin
      case (q_cmd.kind)
        CMD_RISE: begin
          for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (int'(q_cmd.chan) == c) rise_nxt[c] = stamp;
          end
        end
        CMD_FALL: begin
          for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (int'(q_cmd.chan) == c) width_nxt[c] = stamp - rise_r[c];
          end
        end
        CMD_TICK: begin
          slot_nxt = slot_adv;
          for (int c = 0; c < NUM_CHANNELS; c++) begin
            width_ext = CMP_W'(width_r[c]);
            last_ext  = CMP_W'(last_r[c]);
            in_range  = (width_ext >= CMP_W'(low_limit_r)) &&
                        (width_ext <= CMP_W'(high_limit_r));
            checked   = in_range ? width_ext[FIELD_W-1:0] : last_r[c];
            width_nxt[c] = in_range ? width_r[c] : last_ext[TIMER_BITS-1:0];
            last_nxt[c]  = checked;
            for (int k = 0; k < RING_DEPTH; k++) begin
              if (RING_IDX_W'(k) == slot_adv) ring_nxt[c][k] = checked;
            end
            mean[c] = trimmed_mean(ring_nxt[c]);
          end
          for (int f = 0; f < OUT_FIELDS; f++) begin
            out_data_nxt[f*FIELD_W +: FIELD_W] = (f < NUM_CHANNELS) ? mean[f] : '0;
          end
          out_valid_nxt = 1'b1;
        end
        default: begin
          slot_nxt = slot_r;
        end
      endcase
    end
  end

  // Hold configuration and channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_limit_r  <= LOW_LIMIT_RST;
      high_limit_r <= HIGH_LIMIT_RST;
      slot_r       <= '0;
      out_valid_r  <= 1'b0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        rise_r[c]  <= '0;
        width_r[c] <= '0;
        last_r[c]  <= '0;
        ring_r[c]  <= '0;
      end
    end else begin
      if (cfg_we && (cfg_addr == REG_LOW_LIMIT)) low_limit_r <= cfg_wdata;
      if (cfg_we && (cfg_addr == REG_HIGH_LIMIT)) high_limit_r <= cfg_wdata;
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
      rise_r      <= rise_nxt;
      width_r     <= width_nxt;
      last_r      <= last_nxt;
      ring_r      <= ring_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

/* hw/rtl/rc_pulse_capture_filter_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc_pulse_capture_filter_unit: four-channel RC pulse-width receiver
// Measures high-pulse widths per channel and emits a trimmed-mean filtered
// width for every channel on each refine tick.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: tuser is the op (0 capture event, 1 refine tick); tdata
//   carries channel, pin level and the captured timer value. A rising capture
//   stores the rise time, a falling capture sets the pulse width. Captures
//   for absent channels are accepted and dropped.
//   Result stream: one transfer per refine tick with the filtered widths of
//   channels 0..3; captures produce nothing.
//   Configuration: cfg_we writes cfg_wdata to low_limit (index 0) or
//   high_limit (index 1); write only while the unit is idle.
//   Result path: a tick is written into the queue, then executed and
//   registered in the back before it shows up on out_tvalid.
//   Throughput: one item per cycle unless a held result stalls a tick;
//   commands execute on pop; the two-entry queue decouples input from output.
//   Reset: limits return to 800 and 2800, all widths, rise times, rings and
//   the ring slot clear to zero, no result is pending.
//   Stall: a held result keeps the next tick at the head of the queue;
//   input transfers are still taken until the queue fills, then in_tready
//   drops.
// ----------------------------------------------------------------------------
module rc_pulse_capture_filter_unit
  import rcpcf_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int TIMER_BITS   = TIMER_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // configuration write port
  input  wire logic                   cfg_we,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [FIELD_W-1:0]     cfg_wdata,
  // input stream
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,  // channel, pin_level, capture_time
  input  wire logic [IN_TUSER_W-1:0]  in_tuser,  // op
  // result stream
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata  // yaw_out, throttle_out, pitch_out, roll_out
);

  logic q_full;
  logic q_push;
  cmd_t q_push_cmd;
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  rcpcf_front #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_push_cmd)
  );

  rcpcf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_push_cmd),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_cmd   (q_cmd)
  );

  rcpcf_back #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .TIMER_BITS  (TIMER_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire
